[hdl/pmmd_pkg.sv]
package pmmd_pkg;

	localparam int MAX_CHANNELS = 8;
	localparam int CH_W = $clog2(MAX_CHANNELS);
	localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
	localparam int SAMPLE_W = 32;
	localparam int FRAMES_W = 16;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int OUT_DATA_W = 72;

	localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_COUNT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_BYTES = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_FRAMES = 2'd2;

	localparam logic [3:0] RST_CHANNEL_COUNT = 4'd2;
	localparam logic [2:0] RST_SAMPLE_BYTES = 3'd3;
	localparam logic [FRAMES_W-1:0] RST_WINDOW_FRAMES = 16'd20;

	localparam logic ACTION_SAMPLE = 1'b0;
	localparam logic ACTION_FLUSH = 1'b1;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] hi;
		logic signed [SAMPLE_W-1:0] lo;
	} peak_pair_t;

	typedef struct packed {
		logic load;
		logic [CNT_W-1:0] count;
	} emit_req_t;

	function automatic logic signed [SAMPLE_W-1:0] decode_sample(
		input logic [SAMPLE_W-1:0] word,
		input logic [2:0] nbytes
	);
		logic signed [SAMPLE_W-1:0] res;
		if (nbytes <= 3'd2) begin
			res = {{16{word[15]}}, word[15:0]};
		end else if (nbytes == 3'd3) begin
			res = {{8{word[23]}}, word[23:0]};
		end else begin
			res = word;
		end
		return res;
	endfunction

endpackage

[hdl/pcm_min_max_decimator_unit.sv]
// With the result side idle, the sample closing a window, or the flush, passes the input
// stage register, the emitter's snapshot registers and its output register before the first
// result of the window can be transferred out.
// Throughput: one input transfer per cycle; results leave one per channel, one per cycle
// while the sink is ready. Input stalls only when a window closes, or a flush has results
// to give, while the results of the previous run still drain.
// Reset clears the counters, the handshake state and the registers to their defaults;
// the min/max entries are undefined until a sample writes them.
module pcm_min_max_decimator_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// sample_word [31:0]
	input  logic [pmmd_pkg::SAMPLE_W-1:0] s_axis_tdata,
	// action [0]
	input  logic s_axis_tuser,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// channel_index [2:0], peak_high [34:3], peak_low [66:35], zero fill [71:67]
	output logic [pmmd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic m_axis_tlast,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [pmmd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [pmmd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import pmmd_pkg::*;

	logic [3:0] channel_count_q;
	logic [2:0] sample_bytes_q;
	logic [FRAMES_W-1:0] window_frames_q;

	logic valid_s1;
	logic action_s1;
	logic [SAMPLE_W-1:0] word_s1;

	peak_pair_t win_q [MAX_CHANNELS];
	logic [CH_W-1:0] pos_q;
	logic [FRAMES_W-1:0] frames_q;

	logic [CNT_W-1:0] n_eff;
	logic [FRAMES_W-1:0] win_eff;
	logic [CH_W-1:0] pos_eff;
	logic [CNT_W-1:0] pos_next;
	logic signed [SAMPLE_W-1:0] act;
	peak_pair_t cur;
	peak_pair_t merged;
	logic frame_done;
	logic [FRAMES_W:0] frames_inc;
	logic win_done;
	logic emit_now;
	logic advance;
	logic busy;
	emit_req_t req;
	peak_pair_t snap [MAX_CHANNELS];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_count_q <= RST_CHANNEL_COUNT;
			sample_bytes_q <= RST_SAMPLE_BYTES;
			window_frames_q <= RST_WINDOW_FRAMES;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_CHANNEL_COUNT: channel_count_q <= cfg_data[3:0];
				CFG_SAMPLE_BYTES: sample_bytes_q <= cfg_data[2:0];
				CFG_WINDOW_FRAMES: window_frames_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (channel_count_q == 4'd0) begin
			n_eff = CNT_W'(1);
		end else if (CNT_W'(channel_count_q) > CNT_W'(MAX_CHANNELS)) begin
			n_eff = CNT_W'(MAX_CHANNELS);
		end else begin
			n_eff = CNT_W'(channel_count_q);
		end
	end

	assign win_eff = (window_frames_q == '0) ? FRAMES_W'(1) : window_frames_q;
	assign pos_eff = (CNT_W'(pos_q) >= n_eff) ? '0 : pos_q;
	assign pos_next = CNT_W'(pos_eff) + CNT_W'(1);
	assign act = decode_sample(word_s1, sample_bytes_q);
	assign cur = win_q[pos_eff];

	always_comb begin
		merged = cur;
		if (frames_q == '0 || act > cur.hi) begin
			merged.hi = act;
		end
		if (frames_q == '0 || act < cur.lo) begin
			merged.lo = act;
		end
	end

	assign frame_done = pos_next >= n_eff;
	assign frames_inc = {1'b0, frames_q} + (FRAMES_W + 1)'(1);
	assign win_done = frame_done && (frames_inc >= {1'b0, win_eff});
	assign emit_now = (action_s1 == ACTION_FLUSH) ? (frames_q != '0 || pos_q != '0) : win_done;
	assign advance = valid_s1 && !(emit_now && busy);
	assign s_axis_tready = !valid_s1 || advance;

	always_comb begin
		for (int j = 0; j < MAX_CHANNELS; j++) begin
			if (action_s1 == ACTION_SAMPLE && pos_eff == CH_W'(j)) begin
				snap[j] = merged;
			end else begin
				snap[j] = win_q[j];
			end
		end
	end

	assign req = {advance && emit_now, n_eff};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pos_q <= '0;
			frames_q <= '0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				if (action_s1 == ACTION_FLUSH) begin
					pos_q <= '0;
					frames_q <= '0;
				end else if (frame_done) begin
					pos_q <= '0;
					frames_q <= win_done ? '0 : frames_inc[FRAMES_W-1:0];
				end else begin
					pos_q <= pos_next[CH_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			action_s1 <= s_axis_tuser;
			word_s1 <= s_axis_tdata;
		end
		if (advance && action_s1 == ACTION_SAMPLE) begin
			win_q[pos_eff] <= merged;
		end
	end

	pmmd_result_emitter u_emitter (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.snap_in(snap),
		.busy(busy),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

endmodule

[hdl/pmmd_result_emitter.sv]
module pmmd_result_emitter (
	input  logic clk,
	input  logic arst_n,
	input  pmmd_pkg::emit_req_t req,
	input  pmmd_pkg::peak_pair_t snap_in [pmmd_pkg::MAX_CHANNELS],
	output logic busy,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// channel_index [2:0], peak_high [34:3], peak_low [66:35], zero fill [71:67]
	output logic [pmmd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic m_axis_tlast
);
	import pmmd_pkg::*;

	peak_pair_t snap_q [MAX_CHANNELS];
	logic [CNT_W-1:0] count_q;
	logic [CH_W-1:0] idx_q;
	logic busy_q;
	logic out_valid_q;
	logic out_last_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic take;
	logic is_last;

	assign take = busy_q && (!out_valid_q || m_axis_tready);
	assign is_last = (CNT_W'(idx_q) + CNT_W'(1)) == count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			out_valid_q <= 1'b0;
			idx_q <= '0;
			count_q <= '0;
		end else begin
			if (req.load) begin
				busy_q <= 1'b1;
				idx_q <= '0;
				count_q <= req.count;
			end else if (take) begin
				idx_q <= idx_q + CH_W'(1);
				if (is_last) begin
					busy_q <= 1'b0;
				end
			end
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.load) begin
			snap_q <= snap_in;
		end
		if (take) begin
			out_data_q <= {{(OUT_DATA_W - 2 * SAMPLE_W - CH_W){1'b0}},
				snap_q[idx_q].lo, snap_q[idx_q].hi, idx_q};
			out_last_q <= is_last;
		end
	end

	assign busy = busy_q;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;
	assign m_axis_tlast = out_last_q;

endmodule

[tb/sv/pcm_min_max_decimator_unit_tb.sv]
module pcm_min_max_decimator_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pmmd_pkg::*;

	localparam int RUN_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 6;
	localparam int HI_LSB = CH_W;
	localparam int LO_LSB = CH_W + SAMPLE_W;

	typedef struct {
		logic act;
		logic [SAMPLE_W-1:0] word;
	} pcm_item_t;

	typedef struct {
		logic [CH_W-1:0] ch;
		logic signed [SAMPLE_W-1:0] hi;
		logic signed [SAMPLE_W-1:0] lo;
		logic last;
	} peak_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [SAMPLE_W-1:0] s_axis_tdata = '0;
	logic s_axis_tuser = ACTION_SAMPLE;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic m_axis_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = CFG_CHANNEL_COUNT;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic [3:0] cur_count;
	logic [2:0] cur_bytes;
	logic [FRAMES_W-1:0] cur_window;
	logic signed [SAMPLE_W-1:0] peak_min [MAX_CHANNELS];
	logic signed [SAMPLE_W-1:0] peak_max [MAX_CHANNELS];
	int unsigned cur_pos;
	logic [FRAMES_W-1:0] cur_frames;

	pcm_item_t pcm_backlog[$];
	peak_result_t expected_peaks[$];
	int queued_count = 0;
	int accepted_count = 0;
	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int errors = 0;
	int cycles = 0;

	pcm_min_max_decimator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic int unsigned active_channels(input logic [3:0] c);
		if (c == 4'd0) return 1;
		if (c > MAX_CHANNELS) return MAX_CHANNELS;
		return 32'(c);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] widen_sample(input logic [SAMPLE_W-1:0] w);
		if (cur_bytes <= 3'd2) return 32'($signed(w[15:0]));
		if (cur_bytes == 3'd3) return 32'($signed(w[23:0]));
		return $signed(w);
	endfunction

	function automatic void queue_peaks();
		int unsigned n;
		peak_result_t r;
		n = active_channels(cur_count);
		for (int unsigned j = 0; j < n; j++) begin
			r.ch = CH_W'(j);
			r.hi = peak_max[j];
			r.lo = peak_min[j];
			r.last = (j + 1 == n);
			expected_peaks.push_back(r);
		end
	endfunction

	function automatic void merge_pcm_transfer(input logic act, input logic [SAMPLE_W-1:0] w);
		int unsigned n;
		int unsigned win;
		int unsigned pos;
		logic signed [SAMPLE_W-1:0] v;
		n = active_channels(cur_count);
		win = (cur_window == 0) ? 1 : 32'(cur_window);
		if (act == ACTION_FLUSH) begin
			if (cur_frames != 0 || cur_pos != 0) queue_peaks();
			cur_frames = 0;
			cur_pos = 0;
			return;
		end
		v = widen_sample(w);
		pos = (cur_pos >= n) ? 0 : cur_pos;
		if (cur_frames == 0) begin
			peak_min[pos] = v;
			peak_max[pos] = v;
		end else begin
			if (v < peak_min[pos]) peak_min[pos] = v;
			if (v > peak_max[pos]) peak_max[pos] = v;
		end
		pos++;
		if (pos < n) begin
			cur_pos = pos;
			return;
		end
		cur_pos = 0;
		cur_frames = cur_frames + 1'b1;
		if (cur_frames >= win) begin
			cur_frames = 0;
			queue_peaks();
		end
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_word();
		case ($urandom_range(7))
			0: return {16'($urandom), 16'h8000};
			1: return {16'($urandom), 16'h7fff};
			2: return {8'($urandom), 24'h800000};
			3: return {8'($urandom), 24'h7fffff};
			4: return 32'h8000_0000;
			5: return 32'h7fff_ffff;
			default: return $urandom;
		endcase
	endfunction

	task automatic push_item(input logic act, input logic [SAMPLE_W-1:0] w);
		pcm_item_t it;
		it.act = act;
		it.word = w;
		pcm_backlog.push_back(it);
		queued_count++;
	endtask

	task automatic push_samples(input int k);
		for (int i = 0; i < k; i++) push_item(ACTION_SAMPLE, pick_word());
	endtask

	task automatic wait_idle();
		while (accepted_count != queued_count || expected_peaks.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic configure(input int cnt, input int nbytes, input int win);
		wait_idle();
		write_reg(CFG_CHANNEL_COUNT, {12'($urandom), 4'(cnt)});
		write_reg(CFG_SAMPLE_BYTES, {13'($urandom), 3'(nbytes)});
		write_reg(CFG_WINDOW_FRAMES, 16'(win));
	endtask

	task automatic random_phase(input int idle, input int stall, input int cnt, input int budget);
		int sent;
		int n;
		int k;
		int r;
		sent = 0;
		n = active_channels(4'(cnt));
		src_idle_pct = idle;
		sink_stall_pct = stall;
		while (sent < budget) begin
			r = $urandom_range(99);
			if (r < 75) begin
				push_samples(n);
				sent += n;
			end else if (r < 88) begin
				k = $urandom_range(n - 1);
				push_samples(k);
				push_item(ACTION_FLUSH, $urandom);
				sent += k + 1;
			end else if (r < 94) begin
				push_item(ACTION_FLUSH, $urandom);
				sent++;
			end else begin
				push_samples(1);
				sent++;
			end
		end
	endtask

	always @(posedge clk) begin
		pcm_item_t item_out;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (pcm_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				item_out = pcm_backlog.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tuser <= item_out.act;
				s_axis_tdata <= item_out.word;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	always @(posedge clk) begin
		peak_result_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_CHANNEL_COUNT: cur_count = cfg_data[3:0];
					CFG_SAMPLE_BYTES: cur_bytes = cfg_data[2:0];
					CFG_WINDOW_FRAMES: cur_window = cfg_data[FRAMES_W-1:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				merge_pcm_transfer(s_axis_tuser, s_axis_tdata);
				accepted_count++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_peaks.size() == 0) begin
					errors++;
					$display("%0t: unexpected result: expected none, got ch %0d hi %0d lo %0d last %0b",
						$time, m_axis_tdata[CH_W-1:0], $signed(m_axis_tdata[HI_LSB +: SAMPLE_W]),
						$signed(m_axis_tdata[LO_LSB +: SAMPLE_W]), m_axis_tlast);
				end else begin
					want = expected_peaks.pop_front();
					if (m_axis_tdata[CH_W-1:0] !== want.ch
							|| m_axis_tdata[HI_LSB +: SAMPLE_W] !== want.hi
							|| m_axis_tdata[LO_LSB +: SAMPLE_W] !== want.lo
							|| m_axis_tlast !== want.last) begin
						errors++;
						$display("%0t: expected ch %0d hi %0d lo %0d last %0b, got ch %0d hi %0d lo %0d last %0b",
							$time, want.ch, want.hi, want.lo, want.last, m_axis_tdata[CH_W-1:0],
							$signed(m_axis_tdata[HI_LSB +: SAMPLE_W]),
							$signed(m_axis_tdata[LO_LSB +: SAMPLE_W]), m_axis_tlast);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > RUN_LIMIT) begin
			$display("pcm_min_max_decimator_unit test failed");
			$finish;
		end
	end

	initial begin
		cur_count = RST_CHANNEL_COUNT;
		cur_bytes = RST_SAMPLE_BYTES;
		cur_window = RST_WINDOW_FRAMES;
		cur_pos = 0;
		cur_frames = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// One full frame over all eight channels so that every min/max entry holds a value.
		configure(8, 4, 1);
		push_item(ACTION_SAMPLE, 32'h8000_0000);
		push_item(ACTION_SAMPLE, 32'h7fff_ffff);
		push_item(ACTION_SAMPLE, 32'h0000_0000);
		push_item(ACTION_SAMPLE, 32'hffff_ffff);
		push_item(ACTION_SAMPLE, 32'h0000_0001);
		push_samples(3);
		push_item(ACTION_FLUSH, 32'hffff_ffff);

		configure(3, 2, 2);
		push_item(ACTION_SAMPLE, 32'h5a5a_8000);
		push_item(ACTION_SAMPLE, 32'ha5a5_7fff);
		push_item(ACTION_SAMPLE, 32'h0000_ffff);
		push_item(ACTION_SAMPLE, 32'hffff_0001);
		push_item(ACTION_SAMPLE, 32'h1234_0000);
		push_item(ACTION_SAMPLE, 32'h0000_7fff);

		// Flush in the middle of a frame; the third channel reports its old values.
		configure(3, 3, 2);
		push_item(ACTION_SAMPLE, 32'h0080_0000);
		push_item(ACTION_SAMPLE, 32'hff7f_ffff);
		push_item(ACTION_FLUSH, 32'h1234_5678);

		configure(2, 4, 16'hffff);
		push_samples(4);
		push_item(ACTION_FLUSH, 32'h0000_0000);

		// Lowering the channel count mid-frame restarts the frame at channel zero.
		configure(4, 4, 1);
		push_samples(3);
		wait_idle();
		write_reg(CFG_CHANNEL_COUNT, {12'($urandom), 4'd2});
		push_samples(2);

		configure(0, 0, 0);
		random_phase(0, 0, 0, 18);
		configure(15, 7, 2);
		random_phase(59, 0, 15, 18);
		configure(5, 1, 3);
		random_phase(0, 59, 5, 18);
		begin
			int cnt;
			cnt = $urandom_range(1, 8);
			configure(cnt, $urandom_range(2, 4), $urandom_range(1, 4));
			random_phase(11, 11, cnt, 18);
		end

		wait_idle();
		if (errors == 0 && expected_peaks.size() == 0) begin
			$display("pcm_min_max_decimator_unit test passed");
		end else begin
			$display("pcm_min_max_decimator_unit test failed");
		end
		$finish;
	end

endmodule

[files.f]
hdl/pmmd_pkg.sv
hdl/pmmd_result_emitter.sv
hdl/pcm_min_max_decimator_unit.sv
tb/sv/pcm_min_max_decimator_unit_tb.sv
